// ===== hw/rtl/button_gesture_rgb_sequencer_defines.svh =====
// Assertion macros used by the checker of this block.
`ifndef BUTTON_GESTURE_RGB_SEQUENCER_DEFINES_SVH
`define BUTTON_GESTURE_RGB_SEQUENCER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BGRS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bgrs check failed");

// Check a property on every clock edge, reset included.
`define BGRS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bgrs reset check failed");

`endif

// ===== hw/rtl/bgrs_pkg.sv =====
package bgrs_pkg;

    localparam int unsigned LIMIT_W  = 12;
    localparam int unsigned COLOUR_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [LIMIT_W-1:0]  limit_t;
    typedef logic [COLOUR_W-1:0] colour_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes of the configuration port
    localparam cfg_idx_t REG_DEBOUNCE     = 2'd0;
    localparam cfg_idx_t REG_DOUBLE_CLICK = 2'd1;
    localparam cfg_idx_t REG_LONG_PRESS   = 2'd2;
    localparam cfg_idx_t REG_BLINK        = 2'd3;

    localparam limit_t DEBOUNCE_RST     = 12'd50;
    localparam limit_t DOUBLE_CLICK_RST = 12'd150;
    localparam limit_t LONG_PRESS_RST   = 12'd1850;
    localparam limit_t BLINK_RST        = 12'd200;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_DEBOUNCE = 4'b0010,
        PH_WINDOW   = 4'b0100,
        PH_HOLD     = 4'b1000
    } phase_t;

    typedef struct packed {
        logic held;
        logic press_edge;
    } item_t;

    typedef struct packed {
        colour_t colour;
        logic    auto_on;
        logic    down;
    } result_t;

    typedef struct packed {
        limit_t debounce;
        limit_t double_click;
        limit_t long_press;
        limit_t blink;
    } cfg_t;

    // Colour number to pin pattern: bit0 red, bit1 blue, bit2 green
    function automatic colour_t pin_lut(input colour_t c);
        colour_t p;
        case (c)
            3'd0:    p = 3'd0;
            3'd1:    p = 3'd4;
            3'd2:    p = 3'd2;
            3'd3:    p = 3'd6;
            3'd4:    p = 3'd1;
            3'd5:    p = 3'd5;
            3'd6:    p = 3'd3;
            default: p = 3'd7;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/bgrs_in_stage.sv =====
module bgrs_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic           advance,
    input  bgrs_pkg::item_t item_in,
    output logic           valid,
    output bgrs_pkg::item_t item_out
);
    import bgrs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Hold the word until the update stage takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

// ===== hw/rtl/bgrs_gesture_core.sv =====
module bgrs_gesture_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  bgrs_pkg::item_t   item,
    input  bgrs_pkg::cfg_t    cfg,
    output bgrs_pkg::result_t result_next
);
    import bgrs_pkg::*;

    phase_t  phase_reg, phase_next;
    limit_t  count_reg, count_next;
    limit_t  blink_reg, blink_next;
    logic    pending_reg, pending_next;
    colour_t colour_reg, colour_next;
    logic    down_reg, down_next;
    logic    auto_reg, auto_next;
    limit_t  count_inc;
    limit_t  blink_inc;
    colour_t colour_step;
    logic    pend_win;

    assign count_inc   = count_reg + 12'd1;
    assign blink_inc   = blink_reg + 12'd1;
    assign colour_step = down_reg ? colour_reg - 3'd1 : colour_reg + 3'd1;
    assign pend_win    = pending_reg | item.press_edge;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        blink_next   = blink_reg;
        pending_next = pending_reg;
        colour_next  = colour_reg;
        down_next    = down_reg;
        auto_next    = auto_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.press_edge || pending_reg)
                begin
                    auto_next    = 1'b0;
                    pending_next = 1'b0;
                    if (cfg.debounce <= 12'd1)
                    begin
                        phase_next = PH_WINDOW;
                        count_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_DEBOUNCE;
                        count_next = 12'd1;
                    end
                end
                else if (auto_reg)
                begin
                    blink_next = blink_inc;
                    if (blink_inc >= cfg.blink)
                    begin
                        blink_next  = '0;
                        colour_next = colour_step;
                    end
                end
            end
            PH_DEBOUNCE:
            begin
                count_next = count_inc;
                if (count_inc >= cfg.debounce)
                begin
                    phase_next   = PH_WINDOW;
                    count_next   = '0;
                    pending_next = 1'b0;
                end
            end
            PH_WINDOW:
            begin
                pending_next = pend_win;
                count_next   = count_inc;
                if (count_inc >= cfg.double_click)
                begin
                    count_next = '0;
                    if (pend_win)
                    begin
                        pending_next = 1'b0;
                        down_next    = ~down_reg;
                        phase_next   = PH_IDLE;
                    end
                    else if (item.held)
                    begin
                        phase_next = PH_HOLD;
                    end
                    else
                    begin
                        colour_next = colour_step;
                        phase_next  = PH_IDLE;
                    end
                end
            end
            PH_HOLD:
            begin
                pending_next = pend_win;
                if (!item.held)
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                    if (count_inc >= cfg.long_press)
                    begin
                        auto_next  = 1'b1;
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            blink_reg   <= '0;
            pending_reg <= 1'b0;
            colour_reg  <= '0;
            down_reg    <= 1'b0;
            auto_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            blink_reg   <= blink_next;
            pending_reg <= pending_next;
            colour_reg  <= colour_next;
            down_reg    <= down_next;
            auto_reg    <= auto_next;
        end
    end

    assign result_next.colour  = colour_next;
    assign result_next.auto_on = auto_next;
    assign result_next.down    = down_next;

endmodule

// ===== hw/rtl/bgrs_out_stage.sv =====
module bgrs_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              out_ready,
    input  bgrs_pkg::result_t result_in,
    output logic              out_valid,
    output bgrs_pkg::colour_t led_pins,
    output bgrs_pkg::colour_t colour_index,
    output logic              auto_active,
    output logic              counting_down
);
    import bgrs_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    colour_t pins_reg;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= result_in;
            pins_reg <= pin_lut(result_in.colour);
        end
    end

    assign out_valid     = valid_reg;
    assign led_pins      = pins_reg;
    assign colour_index  = res_reg.colour;
    assign auto_active   = res_reg.auto_on;
    assign counting_down = res_reg.down;

endmodule

// ===== hw/rtl/button_gesture_rgb_sequencer.sv =====
// Button gesture RGB sequencer. Feed one word per 1 ms tick carrying the
// held button level and a press-edge flag; each word gives one result word
// with the RGB pin pattern, the colour number and the mode bits after that
// tick. A press runs debounce, then a double-click window: a second press
// reverses the count direction, a release steps the colour, a button still
// held that stays held for long_press_ticks more ticks turns auto mode on.
// In auto mode the colour steps every blink_ticks idle ticks. The block
// takes one word per clock cycle, sustained while out_ready stays high; a
// word passes the input register, then the result register, with all
// tick logic in between. Write the four limit registers over
// cfg_write/cfg_index/cfg_data only while idle; a limit of zero acts as one.
module button_gesture_rgb_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 button_held,
    input  logic                 press_edge,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           led_pins,
    output logic [2:0]           colour_index,
    output logic                 auto_active,
    output logic                 counting_down,
    input  logic                 cfg_write,
    input  bgrs_pkg::cfg_idx_t   cfg_index,
    input  bgrs_pkg::limit_t     cfg_data
);
    import bgrs_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_in;
    item_t   item_s1;
    logic    s1_valid;
    logic    s1_advance;
    logic    in_accept;
    result_t result_next;

    // Configuration registers: plain writes, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce     <= DEBOUNCE_RST;
            cfg_reg.double_click <= DOUBLE_CLICK_RST;
            cfg_reg.long_press   <= LONG_PRESS_RST;
            cfg_reg.blink        <= BLINK_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:     cfg_reg.debounce     <= cfg_data;
                REG_DOUBLE_CLICK: cfg_reg.double_click <= cfg_data;
                REG_LONG_PRESS:   cfg_reg.long_press   <= cfg_data;
                REG_BLINK:        cfg_reg.blink        <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Advance the input word into the update stage whenever the result
    // register is empty or its word leaves this cycle; the input register
    // then frees up for the next word in the same cycle.
    assign s1_advance = s1_valid && (!out_valid || out_ready);
    assign in_ready   = !s1_valid || s1_advance;
    assign in_accept  = in_valid && in_ready;

    assign item_in.held       = button_held;
    assign item_in.press_edge = press_edge;

    bgrs_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_accept),
        .advance  (s1_advance),
        .item_in  (item_in),
        .valid    (s1_valid),
        .item_out (item_s1)
    );

    // Gesture state advances exactly once per word, as it moves on
    bgrs_gesture_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (s1_advance),
        .item        (item_s1),
        .cfg         (cfg_reg),
        .result_next (result_next)
    );

    bgrs_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (s1_advance),
        .out_ready     (out_ready),
        .result_in     (result_next),
        .out_valid     (out_valid),
        .led_pins      (led_pins),
        .colour_index  (colour_index),
        .auto_active   (auto_active),
        .counting_down (counting_down)
    );

endmodule

// ===== hw/rtl/bgrs_checker.sv =====
`include "button_gesture_rgb_sequencer_defines.svh"

module bgrs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] led_pins,
    input logic [2:0] colour_index
);

    // Pin pattern is the bit-reversed colour number
    `BGRS_ASSERT(a_pins_match, out_valid |-> (led_pins[0] == colour_index[2] && led_pins[1] == colour_index[1] && led_pins[2] == colour_index[0]))

    // Downstream taking a word always frees room for a new input word
    `BGRS_ASSERT(a_ready_follows, out_ready |-> in_ready)

    // A stalled result holds
    `BGRS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(colour_index) && $stable(led_pins))

    // An edge seen in reset leaves no result showing at the next edge
    `BGRS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind button_gesture_rgb_sequencer bgrs_checker u_bgrs_checker (.*);
